// ===== hdl/stepper_homing_position_controller_unit_assert.svh =====
`ifndef STEPPER_HOMING_POSITION_CONTROLLER_UNIT_ASSERT_SVH
`define STEPPER_HOMING_POSITION_CONTROLLER_UNIT_ASSERT_SVH

// Check that consq holds in the same cycle as cond
`define SHPC_ASSERT_NOW(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (consq)) \
        else $error(msg);

// Check that consq holds in the cycle after cond
`define SHPC_ASSERT_NEXT(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (consq)) \
        else $error(msg);

`endif

// ===== hdl/shpc_pkg.sv =====
package shpc_pkg;

    localparam int POSITION_BITS = 14;
    localparam int PERIOD_BITS   = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = POSITION_BITS;

    // Stream word widths, rounded up to whole bytes
    localparam int S_TDATA_BITS = ((POSITION_BITS + 2 + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((POSITION_BITS + 5 + 7) / 8) * 8;

    // Mode codes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_HOMING = 2'd1;
    localparam logic [1:0] MODE_MOVING = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_POSITION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_HALF   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_HALF     = 2'd2;

    // Register reset values
    localparam logic [POSITION_BITS-1:0] MAX_POSITION_RESET = POSITION_BITS'(6000);
    localparam logic [PERIOD_BITS-1:0]   START_HALF_RESET   = PERIOD_BITS'(60);
    localparam logic [PERIOD_BITS-1:0]   MIN_HALF_RESET     = PERIOD_BITS'(10);

    typedef struct packed {
        logic [POSITION_BITS-1:0] max_position;
        logic [PERIOD_BITS-1:0]   start_half_period;
        logic [PERIOD_BITS-1:0]   min_half_period;
    } shpc_cfg_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic [POSITION_BITS-1:0] position;
        logic [POSITION_BITS-1:0] goal;
        logic                     homed;
        logic [PERIOD_BITS-1:0]   ramp;
        logic [PERIOD_BITS-1:0]   tick;
        logic                     pulse;
        logic                     dir;
        logic                     enable;
    } shpc_state_t;

    // A zero half-period counts as one tick
    function automatic logic [PERIOD_BITS-1:0] half_ticks(input logic [PERIOD_BITS-1:0] r);
        half_ticks = (r == '0) ? PERIOD_BITS'(1) : r;
    endfunction

endpackage

// ===== hdl/shpc_cfg.sv =====
module shpc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [shpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [shpc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output shpc_pkg::shpc_cfg_t                 cfg
);
    import shpc_pkg::*;

    shpc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_position      <= MAX_POSITION_RESET;
            cfg_reg.start_half_period <= START_HALF_RESET;
            cfg_reg.min_half_period   <= MIN_HALF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_POSITION: cfg_reg.max_position      <= cfg_data;
                CFG_START_HALF:   cfg_reg.start_half_period <= cfg_data[PERIOD_BITS-1:0];
                CFG_MIN_HALF:     cfg_reg.min_half_period   <= cfg_data[PERIOD_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/shpc_core.sv =====
module shpc_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  logic                               tgt_valid,
    input  logic [shpc_pkg::POSITION_BITS-1:0] target,
    input  logic                               home_req,
    input  logic                               endstop_high,
    input  shpc_pkg::shpc_cfg_t                cfg,
    output shpc_pkg::shpc_state_t              state_cur,
    output shpc_pkg::shpc_state_t              state_next
);
    import shpc_pkg::*;

    shpc_state_t state_reg;
    shpc_state_t nxt;
    logic        do_begin;
    logic        do_finish;
    logic [POSITION_BITS-1:0] pos_step;

    // One tick of the homing / move sequencer
    always_comb begin
        nxt       = state_reg;
        do_begin  = 1'b0;
        do_finish = 1'b0;
        pos_step  = state_reg.dir ? state_reg.position + POSITION_BITS'(1)
                                  : state_reg.position - POSITION_BITS'(1);

        if (tgt_valid && (target <= cfg.max_position)) begin
            nxt.goal = target;
        end

        if (state_reg.mode == MODE_IDLE) begin
            if (!state_reg.homed && home_req) begin
                nxt.enable = 1'b1;
                nxt.dir    = 1'b0;
                nxt.ramp   = cfg.start_half_period;
                if (!endstop_high) begin
                    do_finish = 1'b1;
                end else begin
                    nxt.mode = MODE_HOMING;
                    do_begin = 1'b1;
                end
            end else if (state_reg.homed && (nxt.goal != state_reg.position)) begin
                nxt.enable = 1'b1;
                nxt.dir    = nxt.goal > state_reg.position;
                nxt.ramp   = cfg.start_half_period;
                nxt.mode   = MODE_MOVING;
                do_begin   = 1'b1;
            end
        end else if (state_reg.tick > PERIOD_BITS'(1)) begin
            nxt.tick = state_reg.tick - PERIOD_BITS'(1);
        end else if (state_reg.pulse) begin
            nxt.pulse = 1'b0;
            nxt.tick  = half_ticks(state_reg.ramp);
        end else if (state_reg.mode == MODE_HOMING) begin
            if (!endstop_high) begin
                do_finish = 1'b1;
            end else begin
                do_begin = 1'b1;
            end
        end else begin
            // Step complete: advance position, stop at goal or re-aim
            nxt.position = pos_step;
            if (pos_step == nxt.goal) begin
                nxt.mode  = MODE_IDLE;
                nxt.pulse = 1'b0;
                nxt.tick  = '0;
            end else begin
                nxt.dir  = nxt.goal > pos_step;
                do_begin = 1'b1;
            end
        end

        if (do_finish) begin
            nxt.enable   = 1'b0;
            nxt.position = '0;
            nxt.goal     = '0;
            nxt.homed    = 1'b1;
            nxt.pulse    = 1'b0;
            nxt.tick     = '0;
            nxt.mode     = MODE_IDLE;
        end

        // Start a step: ramp down toward the floor, raise the pulse
        if (do_begin) begin
            if (nxt.ramp > cfg.min_half_period) begin
                nxt.ramp = nxt.ramp - PERIOD_BITS'(1);
            end
            nxt.pulse = 1'b1;
            nxt.tick  = half_ticks(nxt.ramp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode     <= MODE_IDLE;
            state_reg.position <= '0;
            state_reg.goal     <= '0;
            state_reg.homed    <= 1'b0;
            state_reg.ramp     <= START_HALF_RESET;
            state_reg.tick     <= '0;
            state_reg.pulse    <= 1'b0;
            state_reg.dir      <= 1'b0;
            state_reg.enable   <= 1'b0;
        end else if (advance) begin
            state_reg <= nxt;
        end
    end

    assign state_cur  = state_reg;
    assign state_next = nxt;

endmodule

// ===== hdl/stepper_homing_position_controller_unit.sv =====
// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tuser, s_tdata (one tick word)
// m_       out        m_tvalid/m_tready   m_tdata (pin levels and status)
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while results are accepted; a taken word goes
// through the input register, then the single-pass state update into the
// result register. Reset is synchronous, active low on aresetn, and clears
// all sequencer state and loads the register defaults. A stalled result
// holds the update; the input register still takes one more word meanwhile.
`include "stepper_homing_position_controller_unit_assert.svh"

module stepper_homing_position_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] new_target_valid
    input  logic [0:0]                          s_tuser,
    // [13:0] target_value, [14] home_request, [15] endstop_level
    input  logic [shpc_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] step_level, [1] direction, [2] driver_enable, [16:3] position,
    // [17] homed, [18] busy_res, [23:19] zero
    output logic [shpc_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [shpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [shpc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import shpc_pkg::*;

    logic                     in_valid_reg;
    logic                     in_tgt_valid_reg;
    logic [POSITION_BITS-1:0] in_target_reg;
    logic                     in_home_reg;
    logic                     in_endstop_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_BITS-1:0]  out_data_reg;
    logic                     advance;
    shpc_cfg_t                cfg;
    shpc_state_t              state_cur;
    shpc_state_t              state_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    shpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    shpc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .tgt_valid    (in_tgt_valid_reg),
        .target       (in_target_reg),
        .home_req     (in_home_reg),
        .endstop_high (in_endstop_reg),
        .cfg          (cfg),
        .state_cur    (state_cur),
        .state_next   (state_next)
    );

    // Hold the incoming word until the update consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tgt_valid_reg <= s_tuser[0];
            in_target_reg    <= s_tdata[POSITION_BITS-1:0];
            in_home_reg      <= s_tdata[POSITION_BITS];
            in_endstop_reg   <= s_tdata[POSITION_BITS+1];
        end
    end

    // Load the result word with the state after this tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= M_TDATA_BITS'({state_next.mode != MODE_IDLE,
                                           state_next.homed,
                                           state_next.position,
                                           state_next.enable,
                                           state_next.dir,
                                           state_next.pulse});
        end
    end

    `SHPC_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, m_tvalid,
        "result word missing after update")
    `SHPC_ASSERT_NOW(a_idle_no_pulse, aclk, aresetn, m_tvalid && !m_tdata[POSITION_BITS+4],
        !m_tdata[0], "step pulse high while not busy")
    `SHPC_ASSERT_NEXT(a_homed_sticks, aclk, aresetn, state_cur.homed,
        state_cur.homed, "homed flag dropped")
    `SHPC_ASSERT_NOW(a_homing_dir, aclk, aresetn, state_cur.mode == MODE_HOMING,
        !state_cur.dir, "homing run not heading home")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import shpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [0:0] s_tuser = '0;               // [0] new_target_valid
    logic [15:0] s_tdata = '0;              // [13:0] target, [14] home_request, [15] endstop
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;                   // [0] step, [1] dir, [2] enable, [16:3] position,
                                            // [17] homed, [18] busy, [23:19] zero
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    stepper_homing_position_controller_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // Motor state and register copies of the predictor
    shpc_cfg_t regs;
    shpc_state_t motor;

    logic [23:0] expected_status[$];
    int error_count = 0;
    int cycle_count = 0;
    bit idling_on = 1'b1;
    bit long_hold_request = 1'b0;

    task automatic report(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    function automatic logic [PERIOD_BITS-1:0] half_len(input logic [PERIOD_BITS-1:0] r);
        return (r == '0) ? PERIOD_BITS'(1) : r;
    endfunction

    function automatic void reset_motor();
        regs.max_position = MAX_POSITION_RESET;
        regs.start_half_period = START_HALF_RESET;
        regs.min_half_period = MIN_HALF_RESET;
        motor.mode = MODE_IDLE;
        motor.position = '0;
        motor.goal = '0;
        motor.homed = 1'b0;
        motor.ramp = START_HALF_RESET;
        motor.tick = '0;
        motor.pulse = 1'b0;
        motor.dir = 1'b0;
        motor.enable = 1'b0;
    endfunction

    // Shorten the ramp toward its floor and raise the step pin
    function automatic void start_step();
        if (motor.ramp > regs.min_half_period)
            motor.ramp = motor.ramp - PERIOD_BITS'(1);
        motor.pulse = 1'b1;
        motor.tick = half_len(motor.ramp);
    endfunction

    function automatic void complete_homing();
        motor.enable = 1'b0;
        motor.position = '0;
        motor.goal = '0;
        motor.homed = 1'b1;
        motor.pulse = 1'b0;
        motor.tick = '0;
        motor.mode = MODE_IDLE;
    endfunction

    // One tick of the controller; returns the expected status word
    function automatic logic [23:0] advance_motor(input bit tv, input logic [13:0] tgt,
                                                  input bit home, input bit endstop);
        if (tv && tgt <= regs.max_position)
            motor.goal = tgt;
        if (motor.mode == MODE_IDLE) begin
            if (!motor.homed && home) begin
                motor.enable = 1'b1;
                motor.dir = 1'b0;
                motor.ramp = regs.start_half_period;
                if (!endstop) begin
                    complete_homing();
                end else begin
                    motor.mode = MODE_HOMING;
                    start_step();
                end
            end else if (motor.homed && motor.goal != motor.position) begin
                motor.enable = 1'b1;
                motor.dir = motor.goal > motor.position;
                motor.ramp = regs.start_half_period;
                motor.mode = MODE_MOVING;
                start_step();
            end
        end else if (motor.tick > 1) begin
            motor.tick = motor.tick - PERIOD_BITS'(1);
        end else if (motor.pulse) begin
            motor.pulse = 1'b0;
            motor.tick = half_len(motor.ramp);
        end else if (motor.mode == MODE_HOMING) begin
            // Endstop is tested only at a step boundary
            if (!endstop)
                complete_homing();
            else
                start_step();
        end else begin
            motor.position = motor.dir ? motor.position + POSITION_BITS'(1)
                                       : motor.position - POSITION_BITS'(1);
            if (motor.position == motor.goal) begin
                motor.mode = MODE_IDLE;
                motor.pulse = 1'b0;
                motor.tick = '0;
            end else begin
                motor.dir = motor.goal > motor.position;
                start_step();
            end
        end
        return {5'b0, motor.mode != MODE_IDLE, motor.homed, motor.position,
                motor.enable, motor.dir, motor.pulse};
    endfunction

    // Offer one tick word, hold it until taken, then predict its status
    task automatic send_tick(input bit tv, input logic [13:0] tgt, input bit home,
                             input bit endstop);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= tv;
        s_tdata <= {endstop, home, tgt};
        do @(posedge aclk); while (!s_tready);
        expected_status.push_back(advance_motor(tv, tgt, home, endstop));
    endtask

    task automatic send_noise();
        send_tick(1'b0, 14'($urandom_range(0, 16383)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // Mostly short hops around the current position, now and then anywhere
    function automatic logic [13:0] pick_target();
        int t;
        int span;
        span = $urandom_range(1, 24);
        case ($urandom_range(0, 9))
            0: t = $urandom_range(0, 16383);
            1: t = int'(regs.max_position);
            2: t = 0;
            default: t = $urandom_range(0, 1) ? int'(motor.position) + span
                                               : int'(motor.position) - span;
        endcase
        if (t < 0)
            t = 0;
        if (t > 16383)
            t = 16383;
        return 14'(t);
    endfunction

    task automatic send_random_tick();
        bit tv;
        tv = ($urandom_range(0, 5) == 0);
        send_tick(tv, tv ? pick_target() : 14'($urandom_range(0, 16383)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_until_idle();
        do send_noise(); while (motor.mode != MODE_IDLE);
    endtask

    // Drop valid and let every pending status word come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_status.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(val);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAX_POSITION: regs.max_position = POSITION_BITS'(val);
            CFG_START_HALF:   regs.start_half_period = PERIOD_BITS'(val);
            CFG_MIN_HALF:     regs.min_half_period = PERIOD_BITS'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_ramp(input int unsigned start_half, input int unsigned min_half);
        write_reg(CFG_START_HALF, start_half);
        write_reg(CFG_MIN_HALF, min_half);
    endtask

    // Targets before homing are stored if in range but never start a move
    task automatic test_unhomed_inputs();
        send_tick(1'b0, 14'h3FFF, 1'b0, 1'b1);
        send_tick(1'b1, 14'd100, 1'b0, 1'b0);
        send_tick(1'b1, 14'd6001, 1'b0, 1'b1);
        send_tick(1'b1, 14'd6000, 1'b0, 1'b1);
        send_tick(1'b1, 14'h3FFF, 1'b0, 1'b0);
        repeat (4) send_tick(1'b0, 14'($urandom_range(0, 16383)), 1'b0,
                             1'($urandom_range(0, 1)));
    endtask

    // Back off toward the endstop for a while, then let the switch close
    task automatic test_homing_run();
        write_ramp(5, 2);
        send_tick(1'b0, 14'd0, 1'b1, 1'b1);
        repeat (60) send_tick(1'($urandom_range(0, 1)), 14'($urandom_range(0, 6000)),
                              1'($urandom_range(0, 1)), 1'b1);
        while (!motor.homed)
            send_tick(1'($urandom_range(0, 1)), 14'($urandom_range(0, 6000)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    endtask

    task automatic test_home_request_ignored();
        repeat (3) send_tick(1'b0, 14'd0, 1'b1, 1'b0);
        send_tick(1'b1, 14'd5, 1'b1, 1'b0);
        repeat (6) send_tick(1'b0, 14'd0, 1'b1, 1'b0);
        run_until_idle();
    endtask

    task automatic test_register_extremes();
        // Smallest travel range
        write_reg(CFG_MAX_POSITION, 1);
        send_tick(1'b1, 14'd1, 1'b0, 1'b1);
        send_tick(1'b1, 14'd2, 1'b0, 1'b1);
        run_until_idle();
        send_tick(1'b1, 14'd0, 1'b0, 1'b1);
        run_until_idle();
        // Full travel range, fastest ramp, reverse mid move
        write_reg(CFG_MAX_POSITION, 16383);
        write_ramp(1, 1);
        send_tick(1'b1, 14'h3FFF, 1'b0, 1'b1);
        repeat (20) send_noise();
        send_tick(1'b1, 14'd3, 1'b0, 1'b1);
        run_until_idle();
        // Floor above the load value keeps the ramp fixed
        write_ramp(3, 9);
        send_tick(1'b1, 14'd6, 1'b0, 1'b1);
        run_until_idle();
        // Slowest ramp, one step
        write_ramp(127, 127);
        send_tick(1'b1, 14'd7, 1'b0, 1'b1);
        run_until_idle();
        // Ramp down to its floor over a longer move
        write_ramp(8, 2);
        send_tick(1'b1, 14'd19, 1'b0, 1'b1);
        run_until_idle();
    endtask

    task automatic test_random_moves();
        int unsigned top;
        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 2))
                0: top = $urandom_range(1, 16383);
                1: top = 16383;
                default: top = $urandom_range(1, 300);
            endcase
            write_reg(CFG_MAX_POSITION, top);
            write_ramp($urandom_range(1, 8), $urandom_range(1, 8));
            repeat (120) send_random_tick();
        end
    endtask

    // Receiver holds off long enough for the input side to back up
    task automatic test_input_backpressure();
        long_hold_request = 1'b1;
        repeat (40) send_random_tick();
    endtask

    task automatic test_steady_stream();
        drain();
        idling_on = 1'b0;
        write_ramp($urandom_range(1, 4), $urandom_range(1, 4));
        repeat (200) send_random_tick();
    endtask

    // Result side ready, with random stalls and one long hold-off
    initial begin : result_receiver
        int n;
        forever begin
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 12);
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Match each status word against the oldest prediction
    always @(posedge aclk) begin : check_results
        logic [23:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                report("status word with no prediction pending");
            end else begin
                want = expected_status.pop_front();
                compare_field("step_level", 16'(m_tdata[0]), 16'(want[0]));
                compare_field("direction", 16'(m_tdata[1]), 16'(want[1]));
                compare_field("driver_enable", 16'(m_tdata[2]), 16'(want[2]));
                compare_field("position", 16'(m_tdata[16:3]), 16'(want[16:3]));
                compare_field("homed", 16'(m_tdata[17]), 16'(want[17]));
                compare_field("busy", 16'(m_tdata[18]), 16'(want[18]));
                compare_field("padding", 16'(m_tdata[23:19]), 16'(want[23:19]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        reset_motor();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_unhomed_inputs();
        test_homing_run();
        test_home_request_ignored();
        test_register_extremes();
        test_random_moves();
        test_input_backpressure();
        test_steady_stream();
        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
